/* rtl/idft_pkg.sv */
// ----------------------------------------------------------------------------
// idft_pkg
// Shared widths, constants and controller/datapath types for the idle timer.
// ----------------------------------------------------------------------------
package idft_pkg;

  localparam int IDLE_W  = 24;
  localparam int DELTA_W = 16;
  localparam int BRT_W   = 8;
  localparam int PCT_W   = 7;
  localparam int FADE_W  = 10;

  localparam int FADE_MS = 500;
  localparam int PCT_MAX = 100;

  // Reset values of the configuration registers.
  localparam logic [IDLE_W-1:0] DIM_AFTER_RST = IDLE_W'(30000);
  localparam logic [IDLE_W-1:0] OFF_AFTER_RST = IDLE_W'(120000);
  localparam logic [BRT_W-1:0]  USER_BRT_RST  = BRT_W'(255);
  localparam logic [PCT_W-1:0]  DIM_PCT_RST   = PCT_W'(30);

  // Division by 100 of a product below 2^15 as a multiply and shift.
  localparam int TPROD_W    = BRT_W + PCT_W;
  localparam int RCP100_SH  = 19;
  localparam int RCP100_W   = 13;
  localparam logic [RCP100_W-1:0] RCP100 = RCP100_W'(((1 << RCP100_SH) / 100) + 1);

  // Division by the fade length as a multiply, shift and one correction step.
  localparam int PROD_W   = BRT_W + FADE_W;
  localparam int FRCP_W   = PROD_W + 1;
  localparam logic [FRCP_W-1:0] FADE_RCP = FRCP_W'((1 << PROD_W) / FADE_MS);
  localparam int QE_W     = FRCP_W;
  localparam int QEF_W    = QE_W + FADE_W;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_DIM_AFTER = 2'd0,
    REG_OFF_AFTER = 2'd1,
    REG_USER_BRT  = 2'd2,
    REG_DIM_PCT   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic tgt;
    logic rcp;
    logic mul;
    logic diva;
    logic divb;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic res_now;
    logic fade_go;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/idft_ctrl.sv */
// ----------------------------------------------------------------------------
// idft_ctrl
// Sequencer that steps one item through evaluation and the brightness math.
// ----------------------------------------------------------------------------
module idft_ctrl
  import idft_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EVAL = 8'b0000_0010,
    S_TGT  = 8'b0000_0100,
    S_RCP  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_DIVA = 8'b0010_0000,
    S_DIVB = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        priority if (st.res_now) begin
          state_nxt = S_EMIT;
        end else if (st.fade_go) begin
          state_nxt = S_TGT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TGT: begin
        cmd.tgt   = 1'b1;
        state_nxt = S_RCP;
      end
      S_RCP: begin
        cmd.rcp   = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIVA;
      end
      S_DIVA: begin
        cmd.diva  = 1'b1;
        state_nxt = S_DIVB;
      end
      S_DIVB: begin
        cmd.divb  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/idft_dp.sv */
// ----------------------------------------------------------------------------
// idft_dp
// Idle and fade state, brightness arithmetic and the result output register.
// ----------------------------------------------------------------------------
module idft_dp
  import idft_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         st,
  input  logic               in_req_type,
  input  logic [DELTA_W-1:0] in_delta_ms,
  input  logic [IDLE_W-1:0]  dim_after_ms,
  input  logic [IDLE_W-1:0]  off_after_ms,
  input  logic [BRT_W-1:0]   user_brightness,
  input  logic [PCT_W-1:0]   dim_percent,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BRT_W-1:0]   out_brightness,
  output logic               out_power_off
);

  logic                         req_r;
  logic [DELTA_W-1:0]           delta_r;
  logic [IDLE_W-1:0]            idle_r;
  logic                         dimmed_r;
  logic [FADE_W-1:0]            fade_r;
  logic                         off_r;
  logic [TPROD_W-1:0]           tprod_r;
  logic [BRT_W-1:0]             tgt_r;
  logic [PROD_W-1:0]            prod_r;
  logic [PROD_W+FRCP_W-1:0]     rprod_r;
  logic [BRT_W-1:0]             res_brt_r;
  logic                         res_pwr_r;
  logic                         out_valid_r;
  logic [BRT_W-1:0]             out_brt_r;
  logic                         out_pwr_r;

  logic [IDLE_W:0]              sum;
  logic [IDLE_W-1:0]            sat;
  logic                         hit_off;
  logic                         dim_now;
  logic [FADE_W-1:0]            fbase;
  logic [DELTA_W:0]             fade_sum;
  logic [FADE_W-1:0]            fnew;
  logic                         fade_go;
  logic [PCT_W-1:0]             pct_c;
  logic [TPROD_W+RCP100_W-1:0]  tq;
  logic [BRT_W-1:0]             diff;
  logic [QE_W-1:0]              qe;
  logic [QEF_W-1:0]             qef;
  logic [QEF_W-1:0]             rem;
  logic [QE_W-1:0]              q;

  always_comb begin
    sum      = {1'b0, idle_r} + {{(IDLE_W+1-DELTA_W){1'b0}}, delta_r};
    sat      = sum[IDLE_W] ? '1 : sum[IDLE_W-1:0];
    hit_off  = (sat >= off_after_ms);
    dim_now  = dimmed_r | (sat >= dim_after_ms);
    fbase    = dimmed_r ? fade_r : '0;
    fade_sum = {{(DELTA_W+1-FADE_W){1'b0}}, fbase} + {1'b0, delta_r};
    fnew     = (fade_sum >= (DELTA_W+1)'(FADE_MS)) ? FADE_W'(FADE_MS)
                                                   : fade_sum[FADE_W-1:0];
    fade_go  = dim_now && (fbase < FADE_W'(FADE_MS));

    pct_c    = (dim_percent > PCT_W'(PCT_MAX)) ? PCT_W'(PCT_MAX) : dim_percent;
    tq       = (TPROD_W+RCP100_W)'(tprod_r) * (TPROD_W+RCP100_W)'(RCP100);
    diff     = user_brightness - tgt_r;

    qe       = rprod_r[PROD_W+FRCP_W-1:PROD_W];
    qef      = QEF_W'(qe) * QEF_W'(FADE_MS);
    rem      = {{(QEF_W-PROD_W){1'b0}}, prod_r} - qef;
    q        = qe + QE_W'(rem >= QEF_W'(FADE_MS));
  end

  always_comb begin
    st.out_free = !out_valid_r || out_ready;
    st.res_now  = 1'b0;
    st.fade_go  = 1'b0;
    if (!off_r) begin
      if (req_r) begin
        st.res_now = dimmed_r;
      end else begin
        st.res_now = hit_off;
        st.fade_go = !hit_off && fade_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r   <= '0;
      dimmed_r <= 1'b0;
      fade_r   <= '0;
      off_r    <= 1'b0;
    end else if (cmd.eval && !off_r) begin
      if (req_r) begin
        idle_r <= '0;
        if (dimmed_r) begin
          dimmed_r <= 1'b0;
          fade_r   <= '0;
        end
      end else begin
        idle_r <= sat;
        if (hit_off) begin
          off_r <= 1'b1;
        end else begin
          dimmed_r <= dim_now;
          fade_r   <= fade_go ? fnew : fbase;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_req_type;
      delta_r <= in_delta_ms;
    end
    if (cmd.eval) begin
      if (req_r) begin
        res_brt_r <= user_brightness;
        res_pwr_r <= 1'b0;
      end else begin
        res_brt_r <= '0;
        res_pwr_r <= 1'b1;
      end
    end
    if (cmd.tgt) begin
      tprod_r <= TPROD_W'(user_brightness) * TPROD_W'(pct_c);
    end
    if (cmd.rcp) begin
      tgt_r <= tq[RCP100_SH+BRT_W-1:RCP100_SH];
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(diff) * PROD_W'(fade_r);
    end
    if (cmd.diva) begin
      rprod_r <= (PROD_W+FRCP_W)'(prod_r) * (PROD_W+FRCP_W)'(FADE_RCP);
    end
    if (cmd.divb) begin
      res_brt_r <= user_brightness - q[BRT_W-1:0];
      res_pwr_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_brt_r <= res_brt_r;
      out_pwr_r <= res_pwr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_brightness = out_brt_r;
  assign out_power_off  = out_pwr_r;

endmodule

/* rtl/idle_dim_fade_poweroff_timer_core.sv */
// ----------------------------------------------------------------------------
// idle_dim_fade_poweroff_timer_core
// Inactivity timer with backlight fade-out and power-off request.
// ----------------------------------------------------------------------------
// One item is handled at a time by a small sequencer. A beat that causes no
// result passes from acceptance through evaluation back to idle; an activity
// beat that restores the brightness, or a tick that requests power off, goes
// from evaluation straight to the emit state; a tick that advances the fade
// runs through the multiply path (target level, reciprocal scale, fade
// product, divide by the fade length and correction) before it is emitted. A
// finished result sits in an output register, and the block only stalls when
// a new result arrives while the previous one is still unread, holding in its
// emit state until it is taken. Configuration registers are at byte addresses
// 0, 4, 8 and 12 and are read back through prdata.
module idle_dim_fade_poweroff_timer_core
  import idft_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [DELTA_W-1:0] in_delta_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BRT_W-1:0]   out_brightness,
  output logic               out_power_off,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [IDLE_W-1:0] dim_after_r;
  logic [IDLE_W-1:0] off_after_r;
  logic [BRT_W-1:0]  user_brt_r;
  logic [PCT_W-1:0]  dim_pct_r;
  reg_idx_t          reg_idx;
  logic              wr_en;
  ctrl_cmd_t         cmd;
  dp_status_t        st;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_after_r <= DIM_AFTER_RST;
      off_after_r <= OFF_AFTER_RST;
      user_brt_r  <= USER_BRT_RST;
      dim_pct_r   <= DIM_PCT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_DIM_AFTER: dim_after_r <= pwdata[IDLE_W-1:0];
        REG_OFF_AFTER: off_after_r <= pwdata[IDLE_W-1:0];
        REG_USER_BRT:  user_brt_r  <= pwdata[BRT_W-1:0];
        REG_DIM_PCT:   dim_pct_r   <= pwdata[PCT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DIM_AFTER: prdata = {{(PDATA_W-IDLE_W){1'b0}}, dim_after_r};
      REG_OFF_AFTER: prdata = {{(PDATA_W-IDLE_W){1'b0}}, off_after_r};
      REG_USER_BRT:  prdata = {{(PDATA_W-BRT_W){1'b0}}, user_brt_r};
      REG_DIM_PCT:   prdata = {{(PDATA_W-PCT_W){1'b0}}, dim_pct_r};
      default:       prdata = '0;
    endcase
  end

  idft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  idft_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_req_type     (in_req_type),
    .in_delta_ms     (in_delta_ms),
    .dim_after_ms    (dim_after_r),
    .off_after_ms    (off_after_r),
    .user_brightness (user_brt_r),
    .dim_percent     (dim_pct_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_brightness  (out_brightness),
    .out_power_off   (out_power_off)
  );

endmodule

/* tb/idle_dim_fade_poweroff_timer_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// idle_dim_fade_poweroff_timer_core_test
// Self-checking bench for the inactivity timer with backlight fade and power off.
// A directed part walks the dim threshold, the fade ramp, restore on activity
// and the percent and limit extremes. Random phases of tick runs broken by
// activity follow, each under its own register setting. A final part drives
// the counter to power off, by saturation or by a zero off limit, and checks
// that later beats are ignored. Every result is compared with an internal
// prediction of the brightness and power-off fields.
// ----------------------------------------------------------------------------
module idle_dim_fade_poweroff_timer_core_test;
  import idft_pkg::*;

  localparam logic REQ_TICK     = 1'b0;
  localparam logic REQ_ACTIVITY = 1'b1;
  localparam int unsigned IDLE_MAX = (1 << IDLE_W) - 1;
  localparam int DRAIN_CYCLES  = 16;
  localparam int MAX_REPORTS   = 10;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 80;

  typedef struct packed {
    logic [BRT_W-1:0] brightness;
    logic             power_off;
  } level_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_req_type = 1'b0;
  logic [DELTA_W-1:0] in_delta_ms = '0;
  logic               out_ready   = 1'b0;
  logic               psel        = 1'b0;
  logic               penable     = 1'b0;
  logic               pwrite      = 1'b0;
  logic [PADDR_W-1:0] paddr       = '0;
  logic [PDATA_W-1:0] pwdata      = '0;
  logic               in_ready;
  logic               out_valid;
  logic [BRT_W-1:0]   out_brightness;
  logic               out_power_off;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Predicted timer state and register copies.
  int unsigned idle_ms     = 0;
  int unsigned fade_ms     = 0;
  bit          dimmed      = 1'b0;
  bit          powered_off = 1'b0;
  int unsigned dim_limit   = 32'(DIM_AFTER_RST);
  int unsigned off_limit   = 32'(OFF_AFTER_RST);
  int unsigned user_level  = 32'(USER_BRT_RST);
  int unsigned dim_pct     = 32'(DIM_PCT_RST);

  level_t pending_levels[$];

  int burst_left   = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int reg_writes   = 0;
  int mismatches   = 0;
  int stall_mode   = 0;
  int stall_run    = 0;

  idle_dim_fade_poweroff_timer_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_delta_ms    (in_delta_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_brightness (out_brightness),
    .out_power_off  (out_power_off),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endtask

  task automatic predict_level(input logic req, input logic [DELTA_W-1:0] delta);
    int unsigned sum;
    int unsigned pct;
    int unsigned target;
    int unsigned d;
    level_t      lvl;
    d = 32'(delta);
    if (powered_off) return;
    if (req == REQ_ACTIVITY) begin
      idle_ms = 0;
      if (dimmed) begin
        dimmed = 1'b0;
        fade_ms = 0;
        lvl.brightness = user_level[BRT_W-1:0];
        lvl.power_off = 1'b0;
        pending_levels.push_back(lvl);
      end
      return;
    end
    sum = idle_ms + d;
    idle_ms = (sum > IDLE_MAX) ? IDLE_MAX : sum;
    if (idle_ms >= off_limit) begin
      powered_off = 1'b1;
      lvl.brightness = '0;
      lvl.power_off = 1'b1;
      pending_levels.push_back(lvl);
      return;
    end
    if (!dimmed && idle_ms >= dim_limit) begin
      dimmed = 1'b1;
      fade_ms = 0;
    end
    if (dimmed && fade_ms < FADE_MS) begin
      fade_ms = (fade_ms + d > FADE_MS) ? FADE_MS : fade_ms + d;
      pct = (dim_pct > PCT_MAX) ? PCT_MAX : dim_pct;
      target = (user_level * pct) / PCT_MAX;
      sum = user_level - ((user_level - target) * fade_ms) / FADE_MS;
      lvl.brightness = sum[BRT_W-1:0];
      lvl.power_off = 1'b0;
      pending_levels.push_back(lvl);
    end
  endtask

  function automatic bit tick_powers_off(input logic [DELTA_W-1:0] delta);
    int unsigned sum;
    sum = idle_ms + 32'(delta);
    if (sum > IDLE_MAX) sum = IDLE_MAX;
    return sum >= off_limit;
  endfunction

  task automatic send_item(input logic req, input logic [DELTA_W-1:0] delta);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if ($urandom_range(0, 2) != 0) gap = $urandom_range(1, 8);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_delta_ms <= delta;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    items_sent++;
    predict_level(req, delta);
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input int unsigned value);
    logic [PDATA_W-1:0] mask;
    logic [PDATA_W-1:0] data;
    case (idx)
      REG_DIM_AFTER, REG_OFF_AFTER: mask = (1 << IDLE_W) - 1;
      REG_USER_BRT:                 mask = (1 << BRT_W) - 1;
      default:                      mask = (1 << PCT_W) - 1;
    endcase
    data = ($urandom & ~mask) | (value & mask);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DIM_AFTER: dim_limit  = data & mask;
      REG_OFF_AFTER: off_limit  = data & mask;
      REG_USER_BRT:  user_level = data & mask;
      default:       dim_pct    = data & mask;
    endcase
    reg_writes++;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== (data & mask)) report_mismatch($sformatf("register %s", idx.name()),
                                                  data & mask, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    level_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_levels.size() == 0) begin
        report_mismatch("unexpected result beat", 32'h0,
                        32'({out_brightness, out_power_off}));
      end else begin
        want = pending_levels.pop_front();
        if (out_brightness !== want.brightness)
          report_mismatch("brightness", 32'(want.brightness), 32'(out_brightness));
        if (out_power_off !== want.power_off)
          report_mismatch("power_off", 32'(want.power_off), 32'(out_power_off));
      end
    end
  end

  // Receiver with its own stall pattern.
  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_run  = $urandom_range(10, 60);
    end
    stall_run--;
    case (stall_mode)
      2:       out_ready <= ($urandom_range(0, 1) == 1);
      3:       out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= 1'b1;
    endcase
  end

  task automatic test_idle_fade_restore();
    send_item(REQ_ACTIVITY, 16'hFFFF);
    send_item(REQ_TICK, 16'd0);
    send_item(REQ_TICK, 16'd29999);
    send_item(REQ_TICK, 16'd1);
    send_item(REQ_TICK, 16'd250);
    send_item(REQ_TICK, 16'hFFFF);
    send_item(REQ_TICK, 16'd0);
    send_item(REQ_ACTIVITY, 16'd0);
    send_item(REQ_ACTIVITY, 16'd0);
    go_idle();
  endtask

  task automatic test_fade_extremes();
    cfg_write(REG_DIM_AFTER, 0);
    cfg_write(REG_DIM_PCT, 127);
    send_item(REQ_TICK, 16'd0);
    send_item(REQ_TICK, 16'd100);
    go_idle();
    // The fade continues with the new level and percent.
    cfg_write(REG_DIM_PCT, 0);
    cfg_write(REG_USER_BRT, 200);
    send_item(REQ_TICK, 16'd200);
    send_item(REQ_TICK, 16'd300);
    send_item(REQ_ACTIVITY, 16'h5A5A);
    go_idle();
    cfg_write(REG_USER_BRT, 0);
    cfg_write(REG_DIM_PCT, 100);
    send_item(REQ_TICK, 16'hFFFF);
    send_item(REQ_ACTIVITY, 16'd0);
    go_idle();
  endtask

  task automatic test_random_phases();
    int          n;
    int          run;
    logic        req;
    logic [15:0] delta;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          cfg_write(REG_DIM_AFTER, 0);
          cfg_write(REG_OFF_AFTER, IDLE_MAX);
          cfg_write(REG_USER_BRT, 255);
          cfg_write(REG_DIM_PCT, 0);
        end
        1: begin
          cfg_write(REG_DIM_AFTER, IDLE_MAX);
          cfg_write(REG_OFF_AFTER, IDLE_MAX);
          cfg_write(REG_USER_BRT, $urandom_range(0, 255));
          cfg_write(REG_DIM_PCT, $urandom_range(0, 127));
        end
        2: begin
          cfg_write(REG_DIM_AFTER, $urandom_range(0, 2000));
          cfg_write(REG_OFF_AFTER, dim_limit + $urandom_range(500, 8000));
          cfg_write(REG_USER_BRT, 0);
          cfg_write(REG_DIM_PCT, 100);
        end
        3: begin
          cfg_write(REG_DIM_AFTER, $urandom_range(0, 3000));
          cfg_write(REG_OFF_AFTER, IDLE_MAX);
          cfg_write(REG_USER_BRT, $urandom_range(0, 255));
          cfg_write(REG_DIM_PCT, 127);
        end
        default: begin
          cfg_write(REG_DIM_AFTER, $urandom_range(0, 5000));
          if ($urandom_range(0, 1) == 1) cfg_write(REG_OFF_AFTER, IDLE_MAX);
          else cfg_write(REG_OFF_AFTER, dim_limit + $urandom_range(0, 40000));
          cfg_write(REG_USER_BRT, $urandom_range(0, 255));
          cfg_write(REG_DIM_PCT, $urandom_range(0, 127));
        end
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        run = $urandom_range(1, 30);
        for (int i = 0; i < run && n < PHASE_ITEMS; i++) begin
          req = REQ_TICK;
          case ($urandom_range(0, 9))
            0:          begin req = REQ_ACTIVITY; delta = DELTA_W'($urandom); end
            1, 2:       delta = DELTA_W'($urandom_range(0, 3000));
            3:          delta = DELTA_W'($urandom);
            default:    delta = DELTA_W'($urandom_range(0, 400));
          endcase
          // Power off would end the run, so such ticks become activity.
          if (req == REQ_TICK && tick_powers_off(delta)) req = REQ_ACTIVITY;
          send_item(req, delta);
          n++;
        end
        if (n < PHASE_ITEMS) begin
          send_item(REQ_ACTIVITY, DELTA_W'($urandom));
          n++;
        end
      end
      go_idle();
    end
  endtask

  task automatic test_power_off();
    bit saturate;
    saturate = 1'($urandom_range(0, 1));
    cfg_write(REG_DIM_AFTER, $urandom_range(0, IDLE_MAX));
    cfg_write(REG_OFF_AFTER, IDLE_MAX);
    send_item(REQ_ACTIVITY, 16'd0);
    if (saturate) begin
      repeat (256) send_item(REQ_TICK, 16'hFFFF);
      send_item(REQ_TICK, 16'hFFFF);
    end else begin
      repeat (256) send_item(REQ_TICK, DELTA_W'($urandom_range(0, 1000)));
      go_idle();
      cfg_write(REG_OFF_AFTER, 0);
      send_item(REQ_TICK, 16'd0);
    end
    repeat (4) begin
      send_item(REQ_TICK, DELTA_W'($urandom));
      send_item(REQ_ACTIVITY, DELTA_W'($urandom));
    end
    go_idle();
    $display("Power off reached by %s.", saturate ? "counter saturation" : "a zero off limit");
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_fade_restore();
    test_fade_extremes();
    test_random_phases();
    test_power_off();
    $display("Sent %0d beats and checked %0d results over %0d register writes.",
             items_sent, results_seen, reg_writes);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0 && pending_levels.size() == 0) begin
      $display("** idle_dim_fade_poweroff_timer_core: PASSED **");
    end else begin
      $display("** idle_dim_fade_poweroff_timer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d results still expected.", pending_levels.size());
    $display("** idle_dim_fade_poweroff_timer_core: FAILED **");
    $finish;
  end

endmodule

/* files.f */
rtl/idft_pkg.sv
rtl/idft_ctrl.sv
rtl/idft_dp.sv
rtl/idle_dim_fade_poweroff_timer_core.sv
tb/idle_dim_fade_poweroff_timer_core_test.sv
